// File: rtl/spiral_order_matrix_reader_defines.svh
// Assertion macros for the spiral order matrix reader.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef SPIRAL_ORDER_MATRIX_READER_DEFINES_SVH
`define SPIRAL_ORDER_MATRIX_READER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SOMR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spiral order matrix reader check failed");

// The consequent must hold in the cycle after the antecedent.
`define SOMR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spiral order matrix reader check failed");

`endif

// File: rtl/somr_pkg.sv
// Shared constants, types and helpers for the spiral order matrix reader.
// No dependencies.
`default_nettype none

package somr_pkg;

    localparam int MAX_ROWS   = 16;
    localparam int MAX_COLS   = 16;
    localparam int DATA_WIDTH = 32;

    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int MAX_DIM = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int SIZE_W = $clog2(MAX_DIM + 1);
    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CFG_IDX_W = 2;

    typedef logic [SIZE_W-1:0]        size_t;
    typedef logic signed [SIZE_W:0]   bound_t;
    typedef logic [ROW_W-1:0]         row_t;
    typedef logic [COL_W-1:0]         col_t;
    typedef logic [ADDR_W-1:0]        addr_t;
    typedef logic [DATA_WIDTH-1:0]    data_t;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 2'd1;

    typedef enum logic [3:0] {
        DIR_RIGHT = 4'b0001,
        DIR_DOWN  = 4'b0010,
        DIR_LEFT  = 4'b0100,
        DIR_UP    = 4'b1000
    } dir_t;

    function automatic size_t clamp_size(input size_t v, input size_t maxv);
        size_t res;
        if (v == '0)
        begin
            res = size_t'(1);
        end
        else if (v > maxv)
        begin
            res = maxv;
        end
        else
        begin
            res = v;
        end
        return res;
    endfunction

    function automatic bound_t last_index(input size_t n);
        return bound_t'({1'b0, n}) - bound_t'(1);
    endfunction

endpackage

`default_nettype wire

// File: rtl/spiral_order_matrix_reader.sv
// Reads: result valid in the cycle after acceptance; one per cycle unless output stalls.
// Write requests are accepted at the same rate and give no result.
// The element store is a 256-entry single-port-write, single-port-read memory whose read
// data is registered; it is not cleared by reset and holds nothing defined until written.
// Reset (rst_n low, asynchronous) sets a 16 x 16 size and puts the walker at the top-left.
// Depends on somr_pkg and spiral_order_matrix_reader_defines.svh.
`default_nettype none

module spiral_order_matrix_reader
    import somr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  cfg_valid,
    output      logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [SIZE_W-1:0]     cfg_data,

    input  wire logic                  in_valid,
    output      logic                  in_ready,
    input  wire logic                  command,
    input  wire logic [ROW_W-1:0]      row_index,
    input  wire logic [COL_W-1:0]      col_index,
    input  wire logic signed [DATA_WIDTH-1:0] element_value,

    output      logic                  out_valid,
    input  wire logic                  out_ready,
    output      logic signed [DATA_WIDTH-1:0] element_out,
    output      logic [ROW_W-1:0]      out_row,
    output      logic [COL_W-1:0]      out_col,
    output      logic                  last
);

    data_t  mem [DEPTH];
    data_t  rdata_reg;

    size_t  rows_reg, rows_next;
    size_t  cols_reg, cols_next;
    bound_t top_reg, top_next;
    bound_t bot_reg, bot_next;
    bound_t left_reg, left_next;
    bound_t right_reg, right_next;
    row_t   cur_row_reg, cur_row_next;
    col_t   cur_col_reg, cur_col_next;
    dir_t   dir_reg, dir_next;

    logic   out_valid_reg, out_valid_next;
    row_t   out_row_reg;
    col_t   out_col_reg;
    logic   last_reg;

    logic   cfg_fire;
    logic   cfg_rows_we;
    logic   cfg_cols_we;
    logic   in_fire;
    logic   rd_fire;
    logic   wr_fire;
    logic   wr_in_range;

    bound_t row_s;
    bound_t col_s;
    bound_t step_top, step_bot, step_left, step_right;
    row_t   step_row;
    col_t   step_col;
    dir_t   step_dir;
    logic   done;

    addr_t  wr_addr;
    addr_t  rd_addr;

    assign cfg_ready   = 1'b1;
    assign cfg_fire    = cfg_valid && cfg_ready;
    assign cfg_rows_we = cfg_fire && (cfg_index == CFG_NUM_ROWS);
    assign cfg_cols_we = cfg_fire && (cfg_index == CFG_NUM_COLS);

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign rd_fire  = in_fire && (command == CMD_READ);
    assign wr_fire  = in_fire && (command == CMD_WRITE);

    assign wr_in_range = (32'(row_index) < 32'(MAX_ROWS)) && (32'(col_index) < 32'(MAX_COLS));
    assign wr_addr = addr_t'(32'(row_index) * 32'(MAX_COLS) + 32'(col_index));
    assign rd_addr = addr_t'(32'(cur_row_reg) * 32'(MAX_COLS) + 32'(cur_col_reg));

    always_ff @(posedge clk)
    begin
        if (wr_fire && wr_in_range)
        begin
            mem[wr_addr] <= data_t'(element_value);
        end
        if (rd_fire)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // One step of the walker, with the bounds moving inward at each corner.
    assign row_s = bound_t'({1'b0, cur_row_reg});
    assign col_s = bound_t'({1'b0, cur_col_reg});

    always_comb
    begin
        step_top   = top_reg;
        step_bot   = bot_reg;
        step_left  = left_reg;
        step_right = right_reg;
        step_row   = cur_row_reg;
        step_col   = cur_col_reg;
        step_dir   = dir_reg;
        done       = 1'b0;
        case (dir_reg)
            DIR_RIGHT:
            begin
                if (col_s < right_reg)
                begin
                    step_col = cur_col_reg + col_t'(1);
                end
                else
                begin
                    step_top = top_reg + bound_t'(1);
                    if (step_top > bot_reg)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        step_dir = DIR_DOWN;
                        step_row = step_top[ROW_W-1:0];
                    end
                end
            end
            DIR_DOWN:
            begin
                if (row_s < bot_reg)
                begin
                    step_row = cur_row_reg + row_t'(1);
                end
                else
                begin
                    step_right = right_reg - bound_t'(1);
                    if (left_reg > step_right)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        step_dir = DIR_LEFT;
                        step_col = step_right[COL_W-1:0];
                    end
                end
            end
            DIR_LEFT:
            begin
                if (col_s > left_reg)
                begin
                    step_col = cur_col_reg - col_t'(1);
                end
                else
                begin
                    step_bot = bot_reg - bound_t'(1);
                    if (top_reg > step_bot)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        step_dir = DIR_UP;
                        step_row = step_bot[ROW_W-1:0];
                    end
                end
            end
            DIR_UP:
            begin
                if (row_s > top_reg)
                begin
                    step_row = cur_row_reg - row_t'(1);
                end
                else
                begin
                    step_left = left_reg + bound_t'(1);
                    if (step_left > right_reg)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        step_dir = DIR_RIGHT;
                        step_col = step_left[COL_W-1:0];
                    end
                end
            end
            default:
            begin
                done = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        rows_next    = cfg_rows_we ? clamp_size(cfg_data, size_t'(MAX_ROWS)) : rows_reg;
        cols_next    = cfg_cols_we ? clamp_size(cfg_data, size_t'(MAX_COLS)) : cols_reg;
        top_next     = top_reg;
        bot_next     = bot_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        dir_next     = dir_reg;
        if (cfg_rows_we || cfg_cols_we || (rd_fire && done))
        begin
            top_next     = '0;
            left_next    = '0;
            bot_next     = last_index(rows_next);
            right_next   = last_index(cols_next);
            cur_row_next = '0;
            cur_col_next = '0;
            dir_next     = DIR_RIGHT;
        end
        else if (rd_fire)
        begin
            top_next     = step_top;
            bot_next     = step_bot;
            left_next    = step_left;
            right_next   = step_right;
            cur_row_next = step_row;
            cur_col_next = step_col;
            dir_next     = step_dir;
        end
    end

    always_comb
    begin
        if (rd_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg      <= size_t'(MAX_ROWS);
            cols_reg      <= size_t'(MAX_COLS);
            top_reg       <= '0;
            left_reg      <= '0;
            bot_reg       <= last_index(size_t'(MAX_ROWS));
            right_reg     <= last_index(size_t'(MAX_COLS));
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            dir_reg       <= DIR_RIGHT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rows_reg      <= rows_next;
            cols_reg      <= cols_next;
            top_reg       <= top_next;
            left_reg      <= left_next;
            bot_reg       <= bot_next;
            right_reg     <= right_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            dir_reg       <= dir_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_fire)
        begin
            out_row_reg <= cur_row_reg;
            out_col_reg <= cur_col_reg;
            last_reg    <= done;
        end
    end

    assign out_valid   = out_valid_reg;
    assign element_out = $signed(rdata_reg);
    assign out_row     = out_row_reg;
    assign out_col     = out_col_reg;
    assign last        = last_reg;

    `include "spiral_order_matrix_reader_defines.svh"

    `SOMR_ASSERT_SAME(a_walker_in_bounds, 1'b1,
        (row_s >= top_reg) && (row_s <= bot_reg) && (col_s >= left_reg) && (col_s <= right_reg))
    `SOMR_ASSERT_NEXT(a_last_returns_home, rd_fire && done && !cfg_fire,
        (cur_row_reg == '0) && (cur_col_reg == '0) && (dir_reg == DIR_RIGHT))
    `SOMR_ASSERT_SAME(a_stall_blocks_input, out_valid_reg && !out_ready, !in_ready)
    `SOMR_ASSERT_NEXT(a_write_gives_no_result, wr_fire && !out_valid_reg, !out_valid_reg)

endmodule

`default_nettype wire

// File: sim/spiral_order_matrix_reader_tb.sv
// Self-checking testbench for spiral_order_matrix_reader: drives write and read requests,
// resizes the matrix between phases and checks every returned element against a spiral walker.
// Depends on somr_pkg and the RTL of spiral_order_matrix_reader.
`timescale 1ns / 1ps

module spiral_order_matrix_reader_tb
    import somr_pkg::*;
;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
    localparam int MAX_REPORTS = 10;

    class spiral_tracker;
        typedef struct {
            data_t value;
            row_t  row;
            col_t  col;
            logic  last;
        } element_t;

        data_t    store [DEPTH];
        bit       written [DEPTH];
        int       rows;
        int       cols;
        int       top_b;
        int       bottom_b;
        int       left_b;
        int       right_b;
        int       cur_row;
        int       cur_col;
        dir_t     heading;
        element_t expected_elements [$];
        int       failures;
        int       wraps;

        function new();
            failures = 0;
            wraps = 0;
            rows = MAX_ROWS;
            cols = MAX_COLS;
            restart();
        endfunction

        function void restart();
            top_b = 0;
            left_b = 0;
            bottom_b = rows - 1;
            right_b = cols - 1;
            cur_row = 0;
            cur_col = 0;
            heading = DIR_RIGHT;
        endfunction

        function int clamp_dim(size_t v, int maxv);
            if (v == '0)
            begin
                return 1;
            end
            if (int'(v) > maxv)
            begin
                return maxv;
            end
            return int'(v);
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, size_t v);
            if (idx == CFG_NUM_ROWS)
            begin
                rows = clamp_dim(v, MAX_ROWS);
                restart();
            end
            else if (idx == CFG_NUM_COLS)
            begin
                cols = clamp_dim(v, MAX_COLS);
                restart();
            end
        endfunction

        function bit cursor_written();
            return written[cur_row * MAX_COLS + cur_col];
        endfunction

        // Moves one position along the spiral and returns 1 once the spiral is complete.
        function bit step();
            case (heading)
                DIR_RIGHT:
                begin
                    if (cur_col < right_b)
                    begin
                        cur_col++;
                        return 1'b0;
                    end
                    top_b++;
                    if (top_b > bottom_b)
                    begin
                        return 1'b1;
                    end
                    heading = DIR_DOWN;
                    cur_row = top_b;
                end
                DIR_DOWN:
                begin
                    if (cur_row < bottom_b)
                    begin
                        cur_row++;
                        return 1'b0;
                    end
                    right_b--;
                    if (left_b > right_b)
                    begin
                        return 1'b1;
                    end
                    heading = DIR_LEFT;
                    cur_col = right_b;
                end
                DIR_LEFT:
                begin
                    if (cur_col > left_b)
                    begin
                        cur_col--;
                        return 1'b0;
                    end
                    bottom_b--;
                    if (top_b > bottom_b)
                    begin
                        return 1'b1;
                    end
                    heading = DIR_UP;
                    cur_row = bottom_b;
                end
                default:
                begin
                    if (cur_row > top_b)
                    begin
                        cur_row--;
                        return 1'b0;
                    end
                    left_b++;
                    if (left_b > right_b)
                    begin
                        return 1'b1;
                    end
                    heading = DIR_RIGHT;
                    cur_col = left_b;
                end
            endcase
            return 1'b0;
        endfunction

        function void note_request(logic cmd, row_t r, col_t c, data_t v);
            element_t e;
            int       idx;
            if (cmd == CMD_WRITE)
            begin
                idx = int'(r) * MAX_COLS + int'(c);
                store[idx] = v;
                written[idx] = 1'b1;
            end
            else
            begin
                e.value = store[cur_row * MAX_COLS + cur_col];
                e.row = row_t'(cur_row);
                e.col = col_t'(cur_col);
                e.last = step();
                if (e.last)
                begin
                    wraps++;
                    restart();
                end
                expected_elements = {expected_elements, e};
            end
        endfunction

        function void check_result(data_t v, row_t r, col_t c, logic l);
            element_t e;
            if (expected_elements.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                begin
                    $display("unexpected element %h at row %0d col %0d last %b", v, r, c, l);
                end
                return;
            end
            e = expected_elements.pop_front();
            if (v !== e.value || r !== e.row || c !== e.col || l !== e.last)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                begin
                    $display("mismatch: expected %h r%0d c%0d last %b, got %h r%0d c%0d last %b",
                             e.value, e.row, e.col, e.last, v, r, c, l);
                end
            end
        endfunction

        function int pending();
            return expected_elements.size();
        endfunction
    endclass

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [CFG_IDX_W-1:0]         cfg_index = '0;
    logic [SIZE_W-1:0]            cfg_data = '0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic                         command = CMD_WRITE;
    logic [ROW_W-1:0]             row_index = '0;
    logic [COL_W-1:0]             col_index = '0;
    logic signed [DATA_WIDTH-1:0] element_value = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic signed [DATA_WIDTH-1:0] element_out;
    logic [ROW_W-1:0]             out_row;
    logic [COL_W-1:0]             out_col;
    logic                         last;

    spiral_tracker tracker;
    bit            in_burst = 1'b0;
    bit            out_burst = 1'b0;
    int            out_stall = 0;

    spiral_order_matrix_reader u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .row_index     (row_index),
        .col_index     (col_index),
        .element_value (element_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .element_out   (element_out),
        .out_row       (out_row),
        .out_col       (out_col),
        .last          (last)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                tracker.check_result(element_out, out_row, out_col, last);
                out_stall = out_burst ? 0 : $urandom_range(0, 3);
                if (out_stall != 0)
                begin
                    out_ready <= 1'b0;
                end
            end
            else if (!out_ready)
            begin
                if (out_stall <= 1)
                begin
                    out_ready <= 1'b1;
                end
                out_stall = out_stall - 1;
            end
        end
    end

    function automatic data_t random_value();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(logic cmd, row_t r, col_t c, data_t v);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        row_index <= r;
        col_index <= c;
        element_value <= v;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.note_request(cmd, r, c, v);
    endtask

    // A read of a never-written entry is outside the contract, so fill it first.
    task automatic read_next();
        if (!tracker.cursor_written())
        begin
            send_request(CMD_WRITE, row_t'(tracker.cur_row), col_t'(tracker.cur_col),
                         random_value());
        end
        send_request(CMD_READ, row_t'($urandom), col_t'($urandom), $urandom);
    endtask

    task automatic random_write();
        send_request(CMD_WRITE, row_t'($urandom_range(0, MAX_ROWS - 1)),
                     col_t'($urandom_range(0, MAX_COLS - 1)), random_value());
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic config_write(logic [CFG_IDX_W-1:0] idx, size_t v);
        cfg_index <= idx;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.write_register(idx, v);
    endtask

    task automatic apply_size(size_t r, size_t c, bit spare);
        cfg_valid <= 1'b1;
        config_write(CFG_NUM_ROWS, r);
        config_write(CFG_NUM_COLS, c);
        if (spare)
        begin
            config_write(CFG_SPARE_LO, size_t'($urandom));
            config_write(CFG_SPARE_HI, size_t'($urandom));
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(int n_items, int read_pct);
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 32 == 0)
            begin
                in_burst = ($urandom_range(0, 3) == 0);
                out_burst = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 99) < read_pct)
            begin
                read_next();
            end
            else
            begin
                random_write();
            end
        end
    endtask

    task automatic run_until_wrap();
        int start;
        int count;
        start = tracker.wraps;
        count = 0;
        while (tracker.wraps == start)
        begin
            if (count % 32 == 0)
            begin
                in_burst = ($urandom_range(0, 3) == 0);
                out_burst = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 99) < 80)
            begin
                read_next();
            end
            else
            begin
                random_write();
            end
            count++;
        end
    endtask

    initial
    begin
        static size_t rows_tab [12] = '{16, 1, 0, 31, 2, 3, 5, 4, 2, 0, 0, 0};
        static size_t cols_tab [12] = '{1, 16, 31, 0, 2, 5, 3, 4, 7, 0, 0, 0};
        tracker = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(CMD_WRITE, 4'd0, 4'd0, 32'h7FFF_FFFF);
        send_request(CMD_WRITE, 4'd0, 4'd15, 32'h8000_0000);
        send_request(CMD_WRITE, 4'd15, 4'd0, 32'hFFFF_FFFF);
        send_request(CMD_WRITE, 4'd15, 4'd15, 32'h0000_0000);
        send_request(CMD_WRITE, 4'd7, 4'd8, 32'h5555_5555);
        send_request(CMD_WRITE, 4'd8, 4'd7, 32'hAAAA_AAAA);
        repeat (3) read_next();
        send_request(CMD_WRITE, 4'd0, 4'd3, 32'h1234_5678);
        read_next();
        drain();
        apply_size(5'd1, 5'd1, 1'b0);
        repeat (2) read_next();

        for (int p = 0; p < 12; p++)
        begin
            drain();
            if (p >= 9)
            begin
                rows_tab[p] = size_t'($urandom_range(1, MAX_ROWS));
                cols_tab[p] = size_t'($urandom_range(1, MAX_COLS));
            end
            apply_size(rows_tab[p], cols_tab[p], bit'($urandom_range(0, 1)));
            run_phase(20, 60);
        end

        drain();
        apply_size(5'd16, 5'd16, 1'b1);
        run_until_wrap();

        in_valid <= 1'b0;
        while (tracker.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (tracker.failures == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/somr_pkg.sv
rtl/spiral_order_matrix_reader.sv
sim/spiral_order_matrix_reader_tb.sv
